@@ sv/ffha_pkg.sv @@
// ffha_pkg: shared types, constants and command/status bundles of the first-fit heap allocator
// used by ffha_ctrl, ffha_dp and first_fit_heap_allocator; depends on nothing else

package ffha_pkg;

    // heap geometry
    localparam int HEAP_BYTES_DEF = 4096;
    localparam int SLOT_BYTES     = 16;
    localparam int HDR_BYTES      = 8;

    // field widths of the channels
    localparam int REQ_W  = 12;
    localparam int PTR_W  = 12;
    localparam int OFF_W  = 12;
    localparam int ST_W   = 2;
    // request rounded up to slots: (request + 8 + 15) >> 4 on a 13-bit sum
    localparam int NEED_W = REQ_W + 1 - 4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPTR = 2'd2;

    // op codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] request_bytes;
        logic [PTR_W-1:0] payload_pointer;
    } item_t;

    typedef struct packed {
        logic [OFF_W-1:0] payload_offset;
        logic [ST_W-1:0]  status;
    } result_t;

    // header read address source
    typedef enum logic {
        RD_ZERO,
        RD_NEXT
    } rd_src_t;

    // header write kinds
    typedef enum logic [1:0] {
        WR_TAKE,
        WR_REST,
        WR_FREE,
        WR_MERGE
    } wr_src_t;

    // result kinds
    typedef enum logic [1:0] {
        RES_GRANT,
        RES_NOFIT,
        RES_BADPTR,
        RES_FREED
    } res_code_t;

    // controller to datapath
    typedef struct packed {
        logic      start;
        logic      rd_en;
        rd_src_t   rd_src;
        logic      wr_en;
        wr_src_t   wr_src;
        logic      head_load;
        logic      acc_add;
        logic      res_load;
        res_code_t res_code;
    } cmd_t;

    // datapath to controller, all about the header last read
    typedef struct packed {
        logic ok;
        logic used;
        logic fits;
        logic split;
        logic hit;
        logic nxt_end;
    } sts_t;

endpackage

@@ sv/ffha_dp.sv @@
// ffha_dp: header memory, walk address, merge accumulator and result register
// depends on ffha_pkg; driven by commands from ffha_ctrl

module ffha_dp #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffha_pkg::item_t   s_payload,
    input  ffha_pkg::cmd_t    cmd,
    output ffha_pkg::sts_t    sts,
    output ffha_pkg::result_t m_payload
);

    localparam int SLOT_COUNT = HEAP_BYTES / ffha_pkg::SLOT_BYTES;
    localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int UW  = IW + 1;
    localparam int HW  = UW + 1;
    localparam int SW  = UW + 1;
    localparam int CW  = (UW > ffha_pkg::NEED_W) ? UW : ffha_pkg::NEED_W;
    localparam int BW  = UW + 4;
    localparam int PCW = (BW > ffha_pkg::PTR_W) ? BW : ffha_pkg::PTR_W;
    localparam int RQW = ffha_pkg::REQ_W + 1;
    localparam logic [UW-1:0] SLOTS     = UW'(SLOT_COUNT);
    localparam logic [HW-1:0] HDR_RESET = {SLOTS, 1'b0};
    localparam logic [RQW-1:0] ROUND_ADD =
        RQW'(ffha_pkg::HDR_BYTES + ffha_pkg::SLOT_BYTES - 1);

    // header store: {units, allocated}
    logic [HW-1:0] mem [SLOT_COUNT];

    logic [HW-1:0]              mem_q_reg;
    logic                       boot_q_reg;
    logic                       hdr0_set_reg;
    logic [UW-1:0]              raddr_reg;
    logic [UW-1:0]              head_reg;
    logic [UW-1:0]              acc_reg;
    logic [ffha_pkg::NEED_W-1:0] need_reg;
    logic [ffha_pkg::PTR_W-1:0] ptr_reg;
    ffha_pkg::result_t          res_reg;

    logic [HW-1:0]  rdata;
    logic [UW-1:0]  du;
    logic           dused;
    logic [SW-1:0]  nxt;
    logic [UW-1:0]  need_u;
    logic [BW-1:0]  byte_off;
    logic [PCW-1:0] byte_off_w;
    logic [IW-1:0]  rd_addr;
    logic [UW-1:0]  wr_addr_u;
    logic [HW-1:0]  wr_data;
    logic [RQW-1:0] need_sum;

    // header last read; entry 0 reads as the whole-heap block until first written
    assign rdata  = boot_q_reg ? HDR_RESET : mem_q_reg;
    assign du     = rdata[HW-1:1];
    assign dused  = rdata[0];
    assign nxt    = {1'b0, raddr_reg} + {1'b0, du};
    assign need_u = UW'(need_reg);

    assign byte_off   = {raddr_reg, 4'h8};
    assign byte_off_w = PCW'(byte_off);

    // status of the current block
    assign sts.ok      = (du != '0) && (nxt <= {1'b0, SLOTS});
    assign sts.used    = dused;
    assign sts.fits    = CW'(need_reg) <= CW'(du);
    assign sts.split   = CW'(du) > CW'(need_reg);
    assign sts.hit     = byte_off_w == PCW'(ptr_reg);
    assign sts.nxt_end = nxt >= {1'b0, SLOTS};

    // read address
    assign rd_addr = (cmd.rd_src == ffha_pkg::RD_ZERO) ? '0 : nxt[IW-1:0];

    // write address and data
    always_comb begin
        case (cmd.wr_src)
            ffha_pkg::WR_TAKE: begin
                wr_addr_u = raddr_reg;
                wr_data   = sts.split ? {need_u, 1'b1} : {du, 1'b1};
            end
            ffha_pkg::WR_REST: begin
                wr_addr_u = UW'(raddr_reg + need_u);
                wr_data   = {UW'(du - need_u), 1'b0};
            end
            ffha_pkg::WR_FREE: begin
                wr_addr_u = raddr_reg;
                wr_data   = {du, 1'b0};
            end
            default: begin
                wr_addr_u = head_reg;
                wr_data   = {acc_reg, 1'b0};
            end
        endcase
    end

    // rounded-up request in slots
    assign need_sum = {1'b0, s_payload.request_bytes} + ROUND_ADD;

    // header memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr_u[IW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // entry 0 reset tracking and read bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr0_set_reg <= 1'b0;
            boot_q_reg   <= 1'b0;
        end else begin
            if (cmd.wr_en && (wr_addr_u == '0)) begin
                hdr0_set_reg <= 1'b1;
            end
            if (cmd.rd_en) begin
                boot_q_reg <= (rd_addr == '0) && !hdr0_set_reg;
            end
        end
    end

    // walk address, merge run and request capture
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            raddr_reg <= UW'(rd_addr);
        end
        if (cmd.head_load) begin
            head_reg <= raddr_reg;
            acc_reg  <= du;
        end else if (cmd.acc_add) begin
            acc_reg <= UW'(acc_reg + du);
        end
        if (cmd.start) begin
            need_reg <= need_sum[RQW-1:4];
            ptr_reg  <= s_payload.payload_pointer;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_code)
                ffha_pkg::RES_GRANT: begin
                    res_reg.payload_offset <= byte_off_w[ffha_pkg::OFF_W-1:0];
                    res_reg.status         <= ffha_pkg::ST_OK;
                end
                ffha_pkg::RES_NOFIT: begin
                    res_reg.payload_offset <= '0;
                    res_reg.status         <= ffha_pkg::ST_NOFIT;
                end
                ffha_pkg::RES_BADPTR: begin
                    res_reg.payload_offset <= '0;
                    res_reg.status         <= ffha_pkg::ST_BADPTR;
                end
                default: begin
                    res_reg.payload_offset <= '0;
                    res_reg.status         <= ffha_pkg::ST_OK;
                end
            endcase
        end
    end

    assign m_payload = res_reg;

endmodule

@@ sv/ffha_ctrl.sv @@
// ffha_ctrl: sequencer for the allocate walk, the free walk and the merge pass
// depends on ffha_pkg; commands ffha_dp and owns the handshakes

module ffha_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_op,
    output logic           m_valid,
    input  logic           m_ready,
    output ffha_pkg::cmd_t cmd,
    input  ffha_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_WALK,
        S_A_SPLIT,
        S_F_WALK,
        S_M_START,
        S_M_OUTER,
        S_M_INNER,
        S_M_FLUSH,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    ffha_pkg::res_code_t   res_code_reg, res_code_next;

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        res_code_next = res_code_reg;
        cmd.start     = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_src    = ffha_pkg::RD_NEXT;
        cmd.wr_en     = 1'b0;
        cmd.wr_src    = ffha_pkg::WR_MERGE;
        cmd.head_load = 1'b0;
        cmd.acc_add   = 1'b0;
        cmd.res_load  = 1'b0;
        cmd.res_code  = res_code_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ffha_pkg::RD_ZERO;
                    state_next = (s_op == ffha_pkg::OP_FREE) ? S_F_WALK : S_A_WALK;
                end
            end
            // first-fit search
            S_A_WALK: begin
                if (!sts.ok) begin
                    res_code_next = ffha_pkg::RES_NOFIT;
                    state_next    = S_RESP;
                end else if (!sts.used && sts.fits) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = ffha_pkg::WR_TAKE;
                    if (sts.split) begin
                        state_next = S_A_SPLIT;
                    end else begin
                        res_code_next = ffha_pkg::RES_GRANT;
                        state_next    = S_RESP;
                    end
                end else if (sts.nxt_end) begin
                    res_code_next = ffha_pkg::RES_NOFIT;
                    state_next    = S_RESP;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            // header of the remainder block
            S_A_SPLIT: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_src    = ffha_pkg::WR_REST;
                res_code_next = ffha_pkg::RES_GRANT;
                state_next    = S_RESP;
            end
            // search for the allocated block at the pointer
            S_F_WALK: begin
                if (!sts.ok) begin
                    res_code_next = ffha_pkg::RES_BADPTR;
                    state_next    = S_RESP;
                end else if (sts.used && sts.hit) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = ffha_pkg::WR_FREE;
                    state_next = S_M_START;
                end else if (sts.nxt_end) begin
                    res_code_next = ffha_pkg::RES_BADPTR;
                    state_next    = S_RESP;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_M_START: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = ffha_pkg::RD_ZERO;
                state_next = S_M_OUTER;
            end
            // merge pass: look for the head of a free run
            S_M_OUTER: begin
                if (!sts.ok) begin
                    res_code_next = ffha_pkg::RES_FREED;
                    state_next    = S_RESP;
                end else if (sts.used) begin
                    if (sts.nxt_end) begin
                        res_code_next = ffha_pkg::RES_FREED;
                        state_next    = S_RESP;
                    end else begin
                        cmd.rd_en = 1'b1;
                    end
                end else begin
                    cmd.head_load = 1'b1;
                    if (sts.nxt_end) begin
                        state_next = S_M_FLUSH;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_M_INNER;
                    end
                end
            end
            // merge pass: absorb following free blocks
            S_M_INNER: begin
                if (!sts.used && sts.ok) begin
                    cmd.acc_add = 1'b1;
                    if (sts.nxt_end) begin
                        state_next = S_M_FLUSH;
                    end else begin
                        cmd.rd_en = 1'b1;
                    end
                end else begin
                    state_next = S_M_FLUSH;
                end
            end
            // write the merged header, then resume on the block still held
            S_M_FLUSH: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffha_pkg::WR_MERGE;
                if (sts.used || !sts.ok) begin
                    state_next = S_M_OUTER;
                end else begin
                    res_code_next = ffha_pkg::RES_FREED;
                    state_next    = S_RESP;
                end
            end
            // hand the result to the output register once it is free
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            res_code_reg <= ffha_pkg::RES_GRANT;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            res_code_reg <= res_code_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// first_fit_heap_allocator: top level joining the sequencer and the header datapath
// depends on ffha_pkg, ffha_ctrl and ffha_dp
//
// Usage:
//   s_ channel carries one request per transfer: op selects allocate or free,
//   request_bytes is the payload wanted, payload_pointer the payload to release.
//   m_ channel returns one result per request, in order: payload_offset of the
//   granted block (zero otherwise) and a status (success, no fit, bad pointer).
// Walks, with N = HEAP_BYTES/16 header slots:
//   allocate walks the block headers from the start to the first free block that fits;
//   free walks to the block, then a merge pass runs over the heap from the start
//   and joins each run of adjacent free blocks into one block.
//   The header memory has a single read port and gives one header per cycle.
// One request is worked on at a time; a new request is taken as soon as the
// previous one has placed its result in the output register, even while that
// result is still waiting for m_ready.
// Reset: the heap is one free block at once, with no clearing pass.
// A stalled receiver holds the result; the block finishes its next request
// and then waits with it until the output register is free.

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffha_pkg::item_t   s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output ffha_pkg::result_t m_payload
);

    ffha_pkg::cmd_t cmd;
    ffha_pkg::sts_t sts;

    // sequencer
    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_payload.op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // header memory and arithmetic
    ffha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // one request in flight: an accepted transfer closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request is in flight");

    // failures carry no offset; frees carry none either, but share ST_OK with grants
    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.status != ffha_pkg::ST_OK)) |->
        (m_payload.payload_offset == '0))
        else $error("offset given with a failing status");

    // granted payloads sit 8 bytes past a slot boundary
    a_offset_align: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.payload_offset != '0)) |->
        (m_payload.payload_offset[3:0] == 4'h8))
        else $error("granted offset not slot aligned");

    // status never takes the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_payload.status == ffha_pkg::ST_OK) ||
                     (m_payload.status == ffha_pkg::ST_NOFIT) ||
                     (m_payload.status == ffha_pkg::ST_BADPTR)))
        else $error("unused status code on the result channel");
`endif

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for first_fit_heap_allocator, with an in-order heap model
// depends on ffha_pkg and first_fit_heap_allocator
`timescale 1ns / 1ps

module tb;

    import ffha_pkg::*;

    localparam int SLOTS       = HEAP_BYTES_DEF / SLOT_BYTES;
    localparam int RAND_ITEMS  = 1150;
    localparam int QUIET_ITEMS = 150;
    localparam int TAIL_CYCLES = 1000;

    logic    aclk;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    item_t   s_payload = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    result_t m_payload;

    // heap model: header per 16-byte slot, (units << 1) | allocated
    logic [9:0]  heap_hdr [SLOTS];
    int unsigned live_ptrs[$];

    item_t   pending_items[$];
    result_t expected_results[$];

    int  accepted_count = 0;
    int  total_items    = 0;
    int  fail_count     = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    bit  hold_off       = 1'b0;

    first_fit_heap_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // timeout
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit valid_block(int unsigned idx, int unsigned units);
        return units != 0 && units <= SLOTS - idx;
    endfunction

    // apply one request to the heap model, keep the pool of live pointers, return the result
    function automatic result_t heap_apply(item_t it);
        int unsigned i, u, j, v, need, k;
        bit          found;
        result_t     res;
        res.payload_offset = '0;
        found = 1'b0;
        i = 0;
        if (it.op == OP_ALLOC) begin
            res.status = ST_NOFIT;
            while (i < SLOTS && !found) begin
                u = heap_hdr[i] >> 1;
                if (!valid_block(i, u))
                    break;
                if (!heap_hdr[i][0] && it.request_bytes + 8 <= u * 16) begin
                    need = (it.request_bytes + 8 + 15) >> 4;
                    if (u - need >= 1) begin
                        heap_hdr[i]        = 10'((need << 1) | 1);
                        heap_hdr[i + need] = 10'((u - need) << 1);
                    end else begin
                        heap_hdr[i][0] = 1'b1;
                    end
                    res.payload_offset = OFF_W'(i * 16 + 8);
                    res.status         = ST_OK;
                    live_ptrs.push_back(i * 16 + 8);
                    found = 1'b1;
                end else begin
                    i += u;
                end
            end
        end else begin
            res.status = ST_BADPTR;
            while (i < SLOTS && !found) begin
                u = heap_hdr[i] >> 1;
                if (!valid_block(i, u))
                    break;
                if (heap_hdr[i][0] && i * 16 + 8 == it.payload_pointer) begin
                    heap_hdr[i][0] = 1'b0;
                    found = 1'b1;
                end else begin
                    i += u;
                end
            end
            if (found) begin
                res.status = ST_OK;
                for (k = 0; k < live_ptrs.size(); k++) begin
                    if (live_ptrs[k] == it.payload_pointer) begin
                        live_ptrs.delete(k);
                        break;
                    end
                end
                // merge every run of adjacent free blocks
                i = 0;
                while (i < SLOTS) begin
                    u = heap_hdr[i] >> 1;
                    if (!valid_block(i, u))
                        break;
                    if (!heap_hdr[i][0]) begin
                        j = i + u;
                        while (j < SLOTS && !heap_hdr[j][0]) begin
                            v = heap_hdr[j] >> 1;
                            if (!valid_block(j, v))
                                break;
                            u += v;
                            j += v;
                        end
                        heap_hdr[i] = 10'(u << 1);
                    end
                    i += u;
                end
            end
        end
        return res;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // idling allowed outside quiet stretches and the final part of the run
    function automatic bit idle_phase();
        return accepted_count < total_items - QUIET_ITEMS && (accepted_count / 128) % 4 != 3;
    endfunction

    // queue one request, the unused field carries random content
    task automatic push_item(logic op, int unsigned req, int unsigned ptr);
        item_t it;
        it.op              = op;
        it.request_bytes   = (op == OP_ALLOC) ? REQ_W'(req) : REQ_W'($urandom);
        it.payload_pointer = (op == OP_FREE) ? PTR_W'(ptr) : PTR_W'($urandom);
        pending_items.push_back(it);
    endtask

    // driver: offers queued requests, random gaps between transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(heap_apply(s_payload));
                accepted_count++;
                if (idle_phase() && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (s_valid && !s_ready) begin
                // hold the offered request
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_valid   <= 1'b1;
                s_payload <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer against the oldest expected one
    always @(posedge aclk) begin
        result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: offset %0d status %0d",
                                           m_payload.payload_offset, m_payload.status));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_payload.payload_offset !== exp_res.payload_offset ||
                        m_payload.status !== exp_res.status)
                        note_failure($sformatf(
                            "mismatch: offset exp %0d got %0d, status exp %0d got %0d",
                            exp_res.payload_offset, m_payload.payload_offset,
                            exp_res.status, m_payload.status));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_off) begin
                m_ready <= 1'b0;
            end else if (idle_phase() && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block fills up and stalls its input
    initial begin
        wait (accepted_count >= 300);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (4000) @(negedge aclk);
        hold_off = 1'b0;
    end

    // reset, stimulus and end of run
    initial begin
        int          n, r, live;
        int unsigned sz, ptr;
        for (n = 0; n < SLOTS; n++)
            heap_hdr[n] = '0;
        heap_hdr[0] = 10'(SLOTS << 1);

        // directed: extremes, exact fit, small remainder, holes, bad pointers
        push_item(OP_ALLOC, 0, 0);
        push_item(OP_ALLOC, 4095, 0);
        push_item(OP_FREE, 0, 8);
        push_item(OP_ALLOC, 4088, 0);
        push_item(OP_ALLOC, 1, 0);
        push_item(OP_FREE, 0, 8);
        push_item(OP_FREE, 0, 8);
        push_item(OP_FREE, 0, 0);
        push_item(OP_FREE, 0, 4095);
        push_item(OP_FREE, 0, 9);
        push_item(OP_ALLOC, 4072, 0);
        push_item(OP_ALLOC, 8, 0);
        push_item(OP_ALLOC, 0, 0);
        push_item(OP_FREE, 0, 4088);
        push_item(OP_FREE, 0, 8);
        push_item(OP_ALLOC, 24, 0);
        push_item(OP_ALLOC, 8, 0);
        push_item(OP_ALLOC, 100, 0);
        push_item(OP_FREE, 0, 40);
        push_item(OP_ALLOC, 9, 0);
        push_item(OP_ALLOC, 8, 0);
        push_item(OP_FREE, 0, 8);
        push_item(OP_FREE, 0, 40);
        push_item(OP_FREE, 0, 56);
        total_items = pending_items.size() + RAND_ITEMS;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // random: mostly frees of live blocks and small allocations
        for (n = 0; n < RAND_ITEMS; n++) begin
            while (pending_items.size() >= 4)
                @(negedge aclk);
            live = live_ptrs.size();
            r    = $urandom_range(0, 99);
            if (live == 0 || (live < 8 && r < 70) || (live >= 8 && live <= 40 && r < 50) ||
                (live > 40 && r < 30)) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    sz = $urandom_range(0, 120);
                else if (r < 95)
                    sz = $urandom_range(0, 1000);
                else
                    sz = $urandom_range(0, 4095);
                push_item(OP_ALLOC, sz, 0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 85 && live > 0)
                    ptr = live_ptrs[$urandom_range(0, live - 1)];
                else if (r < 93)
                    ptr = $urandom_range(0, SLOTS - 1) * 16 + 8;
                else
                    ptr = $urandom_range(0, 4095);
                push_item(OP_FREE, 0, ptr);
            end
        end

        // drain
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
